// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg
// Types and constants shared by the framed command receiver.
// ----------------------------------------------------------------------------
package fcr_pkg;

	localparam int ByteW = 8;
	localparam int AddrW = 3;
	localparam int DataW = 32;

	// register index, taken from paddr[2]
	localparam logic REG_START_CODE = 1'b0;
	localparam logic REG_END_CODE   = 1'b1;

	localparam logic [ByteW-1:0] START_CODE_RST = 8'h02;
	localparam logic [ByteW-1:0] END_CODE_RST   = 8'h03;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_END  = 3'd4
	} phase_t;

	typedef struct packed {
		logic             kind;
		logic [ByteW-1:0] command;
		logic [ByteW-1:0] length;
		logic [ByteW-1:0] index;
		logic [ByteW-1:0] data;
	} result_t;

	typedef struct packed {
		logic [ByteW-1:0] start_code;
		logic [ByteW-1:0] end_code;
	} codes_t;

endpackage

// ===== hdl/fcr_regs.sv =====
// ----------------------------------------------------------------------------
// fcr_regs
// APB register file holding the start and end codes.
// ----------------------------------------------------------------------------
module fcr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fcr_pkg::AddrW-1:0]  paddr,
	input  logic [fcr_pkg::DataW-1:0]  pwdata,
	output logic [fcr_pkg::DataW-1:0]  prdata,
	output logic                       pready,
	output fcr_pkg::codes_t            codes
);
	import fcr_pkg::*;

	logic [ByteW-1:0] start_code_q;
	logic [ByteW-1:0] end_code_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= START_CODE_RST;
			end_code_q   <= END_CODE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_START_CODE: start_code_q <= pwdata[ByteW-1:0];
				REG_END_CODE:   end_code_q   <= pwdata[ByteW-1:0];
				default: ;
			endcase
		end
	end

	// read back the addressed register
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_START_CODE: prdata[ByteW-1:0] = start_code_q;
			REG_END_CODE:   prdata[ByteW-1:0] = end_code_q;
			default: ;
		endcase
	end

	assign codes.start_code = start_code_q;
	assign codes.end_code   = end_code_q;

endmodule

// ===== hdl/fcr_parser.sv =====
// ----------------------------------------------------------------------------
// fcr_parser
// Input register and frame state machine; builds one result per byte at most.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcr_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [fcr_pkg::ByteW-1:0]  rx_byte,
	input  fcr_pkg::codes_t            codes,
	input  logic                       res_free,
	output logic                       res_load,
	output fcr_pkg::result_t           res_d
);
	import fcr_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             advance;

	phase_t           phase_q, phase_d, phase_eff;
	logic [ByteW-1:0] cmd_q, cmd_d;
	logic [ByteW-1:0] len_q, len_d;
	logic [ByteW-1:0] cnt_q, cnt_d;
	logic             end_hit;

	// the byte moves on once the result register can take whatever it yields
	assign advance  = valid_s1 & res_free;
	assign rx_ready = ~valid_s1 | advance;

	// hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && rx_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// a full payload turns into the end phase before the byte is looked at
	assign phase_eff = (phase_q == PH_DATA && cnt_q >= len_q) ? PH_END : phase_q;
	assign end_hit   = (byte_s1 == codes.end_code);

	// next state
	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		if (advance) begin
			phase_d = phase_eff;
			unique case (phase_eff)
				PH_HUNT: begin
					if (byte_s1 == codes.start_code) begin
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_d   = byte_s1;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					len_d   = byte_s1;
					cnt_d   = '0;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					cnt_d = cnt_q + ByteW'(1);
				end
				PH_END: begin
					if (end_hit) begin
						cnt_d   = '0;
						phase_d = PH_HUNT;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// result for the result register
	always_comb begin
		res_load      = 1'b0;
		res_d.kind    = KIND_PAYLOAD;
		res_d.command = cmd_q;
		res_d.length  = len_q;
		res_d.index   = cnt_q;
		res_d.data    = byte_s1;
		unique case (phase_eff)
			PH_DATA: res_load = advance;
			PH_END: begin
				res_load    = advance & end_hit;
				res_d.kind  = KIND_DONE;
				res_d.index = '0;
				res_d.data  = '0;
			end
			default: ;
		endcase
	end

	// advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cmd_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	`ASSERT_NEXT(a_done_to_hunt, clk, arst_n, res_load && res_d.kind == KIND_DONE, phase_q == PH_HUNT, "frame done did not return to hunt")
	`ASSERT_IMPLIES(a_cnt_le_len, clk, arst_n, phase_q == PH_DATA, cnt_q <= len_q, "payload count passed frame length")
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1), "stalled byte lost")

endmodule

// ===== hdl/fcr_out_reg.sv =====
// ----------------------------------------------------------------------------
// fcr_out_reg
// Result register presenting one result item to the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_load,
	input  fcr_pkg::result_t    res_d,
	output logic                res_free,
	output logic                out_valid,
	input  logic                out_ready,
	output fcr_pkg::result_t    res_q
);
	import fcr_pkg::*;

	logic valid_q;

	assign res_free  = ~valid_q | out_ready;
	assign out_valid = valid_q;

	// load a new result or drop the delivered one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	`ASSERT_IMPLIES(a_load_free, clk, arst_n, res_load, !valid_q || out_ready, "result overwritten before transfer")

endmodule

// ===== hdl/framed_command_receiver.sv =====
// ----------------------------------------------------------------------------
// framed_command_receiver
// Frame parser: start code, command, length, payload bytes, end code.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and follows the frame. Each payload
// byte comes out as a result with its index, the frame's command and length;
// the end code yields one frame-done result. Bytes before a start code and
// non-matching bytes in the end phase yield nothing. A transferred byte is
// held in the input register, and its result is loaded into the result
// register once that register is free; it goes out from the result register.
// One byte is taken per cycle, sustained while the receiver takes results,
// since the whole phase update is combinational logic between the input
// register and the result register. While the receiver holds off a result,
// one more byte waits in the input register and then the input stalls.
// Start and end codes sit at byte addresses 0 and 4 of the APB port.
module framed_command_receiver (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fcr_pkg::AddrW-1:0]  paddr,
	input  logic [fcr_pkg::DataW-1:0]  pwdata,
	output logic [fcr_pkg::DataW-1:0]  prdata,
	output logic                       pready,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [fcr_pkg::ByteW-1:0]  rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       result_kind,
	output logic [fcr_pkg::ByteW-1:0]  command_byte,
	output logic [fcr_pkg::ByteW-1:0]  frame_length,
	output logic [fcr_pkg::ByteW-1:0]  byte_index,
	output logic [fcr_pkg::ByteW-1:0]  payload_byte
);
	import fcr_pkg::*;

	codes_t  codes;
	logic    res_free;
	logic    res_load;
	result_t res_d;
	result_t res_q;

	fcr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.codes   (codes)
	);

	fcr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.codes    (codes),
		.res_free (res_free),
		.res_load (res_load),
		.res_d    (res_d)
	);

	fcr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res_d     (res_d),
		.res_free  (res_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// present the result fields
	assign result_kind  = res_q.kind;
	assign command_byte = res_q.command;
	assign frame_length = res_q.length;
	assign byte_index   = res_q.index;
	assign payload_byte = res_q.data;

endmodule

// ===== tb/tb_framed_command_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_command_receiver
// Self-checking bench for the start/command/length/payload/end frame parser.
// ----------------------------------------------------------------------------
// A directed table walks reset codes, zero-length frames, dropped bytes in
// the end phase and a payload byte equal to the end code. Random frames follow,
// mostly well formed, with noise, truncated frames and missing end codes, under
// several start/end code settings written over APB. Every result is checked
// against the table row or a frame tracker that mirrors the parser, with random
// stalls on both sides, one long receiver hold-off and a stretch with no stalls.
module tb_framed_command_receiver;
	import fcr_pkg::*;

	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT      = 16;
	localparam int DIRECTED_ROWS = 20;

	localparam result_t NO_RESULT = '0;

	typedef struct packed {
		logic [ByteW-1:0] rx;
		logic             typed;
		logic             has_result;
		result_t          result;
	} frame_row_t;

	localparam frame_row_t NO_ROW = '0;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AddrW-1:0]  paddr;
	logic [DataW-1:0]  pwdata;
	logic [DataW-1:0]  prdata;
	logic              pready;
	logic              rx_valid;
	logic              rx_ready;
	logic [ByteW-1:0]  rx_byte;
	logic              out_valid;
	logic              out_ready;
	logic              result_kind;
	logic [ByteW-1:0]  command_byte;
	logic [ByteW-1:0]  frame_length;
	logic [ByteW-1:0]  byte_index;
	logic [ByteW-1:0]  payload_byte;

	// frame tracker state and code mirror
	phase_t            trk_phase;
	logic [ByteW-1:0]  trk_command;
	logic [ByteW-1:0]  trk_length;
	logic [ByteW-1:0]  trk_count;
	logic [ByteW-1:0]  start_code_q;
	logic [ByteW-1:0]  end_code_q;

	result_t           pending_results [$];
	frame_row_t        directed_rows [DIRECTED_ROWS];
	frame_row_t        cur_row;
	int                mismatch_count;
	bit                steady;
	bit                hold_req;

	framed_command_receiver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.command_byte (command_byte),
		.frame_length (frame_length),
		.byte_index   (byte_index),
		.payload_byte (payload_byte)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t mk_result(logic k, logic [ByteW-1:0] c, logic [ByteW-1:0] l,
			logic [ByteW-1:0] i, logic [ByteW-1:0] d);
		result_t r;
		r.kind    = k;
		r.command = c;
		r.length  = l;
		r.index   = i;
		r.data    = d;
		return r;
	endfunction

	// advance the frame tracker by one received byte; return 1 on a result
	function automatic bit track_byte(input logic [ByteW-1:0] b, output result_t r);
		bit hit;
		hit = 1'b0;
		r   = NO_RESULT;
		// payload complete: switch to the end phase before looking at the byte
		if (trk_phase == PH_DATA && trk_count >= trk_length)
			trk_phase = PH_END;
		case (trk_phase)
			PH_HUNT: begin
				if (b == start_code_q)
					trk_phase = PH_CMD;
			end
			PH_CMD: begin
				trk_command = b;
				trk_phase   = PH_LEN;
			end
			PH_LEN: begin
				trk_length = b;
				trk_count  = '0;
				trk_phase  = PH_DATA;
			end
			PH_DATA: begin
				r         = mk_result(KIND_PAYLOAD, trk_command, trk_length, trk_count, b);
				trk_count = trk_count + 8'd1;
				hit       = 1'b1;
			end
			PH_END: begin
				if (b == end_code_q) begin
					r         = mk_result(KIND_DONE, trk_command, trk_length, '0, '0);
					trk_count = '0;
					trk_phase = PH_HUNT;
					hit       = 1'b1;
				end
			end
			default: trk_phase = PH_HUNT;
		endcase
		return hit;
	endfunction

	task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
		$display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(string what, logic [ByteW-1:0] got, logic [ByteW-1:0] want);
		if (got !== want)
			report_mismatch(what, DataW'(got), DataW'(want));
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk) begin
		result_t r;
		result_t want;
		bit      hit;
		if (arst_n) begin
			if (rx_valid && rx_ready) begin
				hit = track_byte(rx_byte, r);
				if (cur_row.typed) begin
					if (cur_row.has_result)
						pending_results.push_back(cur_row.result);
				end else if (hit) begin
					pending_results.push_back(r);
				end
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", DataW'(payload_byte), '0);
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", {7'd0, result_kind}, {7'd0, want.kind});
					check_field("command_byte", command_byte, want.command);
					check_field("frame_length", frame_length, want.length);
					check_field("byte_index", byte_index, want.index);
					check_field("payload_byte", payload_byte, want.data);
				end
			end
		end
	end

	// receiver side: random stalls, long hold-off on request
	initial begin
		int held;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				out_ready = 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(negedge clk);
			end else begin
				out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// offer one byte, hold it until the transfer
	task automatic send_byte(input logic [ByteW-1:0] b, input frame_row_t row);
		@(negedge clk);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				rx_valid = 1'b0;
				@(negedge clk);
			end
		end
		rx_valid = 1'b1;
		rx_byte  = b;
		cur_row  = row;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
	endtask

	task automatic send_random(input logic [ByteW-1:0] b);
		send_byte(b, NO_ROW);
	endtask

	function automatic logic [ByteW-1:0] byte_other_than(input logic [ByteW-1:0] v);
		logic [ByteW-1:0] b;
		b = 8'($urandom);
		if (b == v)
			b = v + 8'd1;
		return b;
	endfunction

	// one frame: start, command, length, n_payload bytes, optional end phase
	task automatic send_frame(input int len, input int n_payload, input bit with_end,
			input bit with_code, inout int sent);
		int n;
		send_random(start_code_q);
		send_random(8'($urandom));
		send_random(len[ByteW-1:0]);
		sent += 3;
		repeat (n_payload)
			send_random(8'($urandom));
		sent += n_payload;
		if (with_end) begin
			// drop some stray bytes in the end phase
			n = $urandom_range(0, 2);
			repeat (n)
				send_random(byte_other_than(end_code_q));
			if (with_code)
				send_random(end_code_q);
			sent += n + 1;
		end
	endtask

	// mostly well-formed frames with noise, truncation and missing end codes
	task automatic send_stream(input int budget);
		int sent;
		int sel;
		int len;
		int n;
		sent = 0;
		while (sent < budget) begin
			n = $urandom_range(0, 2);
			repeat (n)
				send_random(byte_other_than(start_code_q));
			sent += n;
			sel = $urandom_range(99);
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			if (sel < 8) begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_random(8'($urandom));
				sent += n;
			end else if (sel < 18) begin
				n = (len > 0) ? $urandom_range(0, len - 1) : 0;
				send_frame(len, n, 1'b0, 1'b0, sent);
			end else begin
				send_frame(len, len, 1'b1, sel >= 24, sent);
			end
		end
	endtask

	// drop valid and wait for every pending result
	task automatic drain_results();
		@(negedge clk);
		rx_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx, input logic [DataW-1:0] wdata,
			output logic [DataW-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		if (wr) begin
			if (idx == REG_START_CODE)
				start_code_q = wdata[ByteW-1:0];
			else
				end_code_q = wdata[ByteW-1:0];
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// write both codes with random upper bits, then read them back
	task automatic set_codes(input logic [ByteW-1:0] sc, input logic [ByteW-1:0] ec);
		logic [DataW-1:0] rd;
		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		apb_access(1'b1, REG_START_CODE, {24'($urandom), sc}, rd);
		apb_access(1'b1, REG_END_CODE, {24'($urandom), ec}, rd);
		apb_access(1'b0, REG_START_CODE, '0, rd);
		check_field("start_code readback", rd[ByteW-1:0], start_code_q);
		apb_access(1'b0, REG_END_CODE, '0, rd);
		check_field("end_code readback", rd[ByteW-1:0], end_code_q);
	endtask

	initial begin
		int i;
		int sent;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		rx_valid       = 1'b0;
		rx_byte        = '0;
		cur_row        = NO_ROW;
		steady         = 1'b0;
		hold_req       = 1'b0;
		mismatch_count = 0;
		sent           = 0;
		trk_phase      = PH_HUNT;
		trk_command    = '0;
		trk_length     = '0;
		trk_count      = '0;
		start_code_q   = START_CODE_RST;
		end_code_q     = END_CODE_RST;

		// reset codes: start 0x02, end 0x03
		directed_rows[0]  = '{8'h00, 1'b1, 1'b0, NO_RESULT};
		directed_rows[1]  = '{8'hFF, 1'b1, 1'b0, NO_RESULT};
		directed_rows[2]  = '{8'h03, 1'b1, 1'b0, NO_RESULT};
		directed_rows[3]  = '{8'h02, 1'b0, 1'b0, NO_RESULT};
		directed_rows[4]  = '{8'hFF, 1'b0, 1'b0, NO_RESULT};
		// zero length: next byte already faces the end code
		directed_rows[5]  = '{8'h00, 1'b0, 1'b0, NO_RESULT};
		directed_rows[6]  = '{8'h55, 1'b1, 1'b0, NO_RESULT};
		directed_rows[7]  = '{8'h03, 1'b1, 1'b1, mk_result(KIND_DONE, 8'hFF, 8'h00, 8'h00, 8'h00)};
		directed_rows[8]  = '{8'h02, 1'b0, 1'b0, NO_RESULT};
		directed_rows[9]  = '{8'h00, 1'b0, 1'b0, NO_RESULT};
		directed_rows[10] = '{8'h02, 1'b0, 1'b0, NO_RESULT};
		directed_rows[11] = '{8'hFF, 1'b1, 1'b1, mk_result(KIND_PAYLOAD, 8'h00, 8'h02, 8'h00, 8'hFF)};
		directed_rows[12] = '{8'h00, 1'b1, 1'b1, mk_result(KIND_PAYLOAD, 8'h00, 8'h02, 8'h01, 8'h00)};
		// start code in the end phase is dropped
		directed_rows[13] = '{8'h02, 1'b0, 1'b0, NO_RESULT};
		directed_rows[14] = '{8'h03, 1'b0, 1'b0, NO_RESULT};
		directed_rows[15] = '{8'h02, 1'b0, 1'b0, NO_RESULT};
		directed_rows[16] = '{8'hA5, 1'b0, 1'b0, NO_RESULT};
		directed_rows[17] = '{8'h01, 1'b0, 1'b0, NO_RESULT};
		// payload byte equal to the end code is still payload
		directed_rows[18] = '{8'h03, 1'b0, 1'b0, NO_RESULT};
		directed_rows[19] = '{8'h03, 1'b0, 1'b0, NO_RESULT};

		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++)
			send_byte(directed_rows[i].rx, directed_rows[i]);
		send_stream(100);

		// extreme codes, with one frame of the longest length
		set_codes(8'h00, 8'hFF);
		send_frame(255, 255, 1'b1, 1'b1, sent);
		send_stream(60);

		// long receiver hold-off while bytes keep coming, then a full pause
		set_codes(8'hFF, 8'h00);
		hold_req = 1'b1;
		send_stream(60);
		drain_results();
		send_stream(40);

		// equal codes, no stalls on either side
		set_codes(8'h5A, 8'h5A);
		steady = 1'b1;
		send_stream(100);
		steady = 1'b0;

		set_codes(8'($urandom), 8'($urandom));
		send_stream(100);

		set_codes(START_CODE_RST, END_CODE_RST);
		send_stream(50);

		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stop a hung run
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
